// ===== rtl/m3inv_pkg.sv =====
// m3inv_pkg: types and constants shared by the 3x3 matrix inverse core
// holds the transaction structs, datapath widths and the cofactor index tables
// depends on nothing
package m3inv_pkg;

    localparam int W  = 32;   // entry width, signed Q16.16
    localparam int CW = 64;   // cofactor width, signed Q32.32
    localparam int DW = 98;   // determinant width, signed Q48.48 plus headroom
    localparam int QB = 32;   // quotient bits formed by the divider
    localparam int NE = 9;    // entries per matrix

    typedef logic signed [W-1:0] t_fix;
    typedef logic [3:0]          t_idx;

    typedef struct packed {
        t_fix in_r0c0;
        t_fix in_r0c1;
        t_fix in_r0c2;
        t_fix in_r1c0;
        t_fix in_r1c1;
        t_fix in_r1c2;
        t_fix in_r2c0;
        t_fix in_r2c1;
        t_fix in_r2c2;
    } t_in_item;

    typedef struct packed {
        t_fix out_r0c0;
        t_fix out_r0c1;
        t_fix out_r0c2;
        t_fix out_r1c0;
        t_fix out_r1c1;
        t_fix out_r1c2;
        t_fix out_r2c0;
        t_fix out_r2c1;
        t_fix out_r2c2;
        logic singular;
        logic saturated;
    } t_out_item;

    // cofactor k = m[A]*m[B] - m[C]*m[D], row-major entry indexes
    localparam t_idx COF_A [NE] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam t_idx COF_B [NE] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam t_idx COF_C [NE] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam t_idx COF_D [NE] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    localparam logic [W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

// ===== rtl/matrix3_inverse_core.sv =====
// matrix3_inverse_core: pipelined 3x3 matrix inverse by adjugate over determinant
// exact fixed-point cofactors and determinant, 32-stage restoring divider lanes
// depends on m3inv_pkg
//
// usage
//   input channel: i_valid / o_stall carry one matrix per transaction, nine signed
//   Q16.16 entries in row-major order. output channel: o_valid / i_stall carry the
//   nine Q16.16 entries of the inverse plus singular and saturated flags
//   throughput: one matrix per cycle when not stalled, every stage is a register
//   stage with a valid bit, so back to back transactions fill the whole pipe
//   stages: 1 entry products, 2 cofactors, 3 split determinant products,
//   4 rejoin products, 5 determinant sum, 6 magnitudes and signs, 7 overflow test,
//   8..39 one quotient bit per stage in nine parallel lanes, 40 clamp and output
//   a zero determinant gives zero entries with singular set
//   reset (synchronous, active low) clears only the valid bits; data regs are free
//   when the receiver stalls a waiting result the whole pipe freezes and o_stall
//   goes high, so nothing is dropped or repeated; bubbles keep moving otherwise
module matrix3_inverse_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  m3inv_pkg::t_in_item   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output m3inv_pkg::t_out_item  o_data
);
    import m3inv_pkg::*;

    localparam int NSTG = 7 + QB + 1;

    // valid bits, bit 0 is stage 1, top bit is the output register
    logic [NSTG-1:0] r_vld;
    logic            w_en;

    // stage 1: the 18 entry products
    logic signed [W-1:0]    w_m    [NE];
    logic signed [CW-1:0]   n_pa   [NE];
    logic signed [CW-1:0]   n_pb   [NE];
    logic signed [CW-1:0]   r1_pa  [NE];
    logic signed [CW-1:0]   r1_pb  [NE];
    logic signed [W-1:0]    r1_m   [3];

    // stage 2: cofactors
    logic signed [CW-1:0]   r2_cof [NE];
    logic signed [W-1:0]    r2_m   [3];

    // stage 3: determinant products split into low and high halves of the cofactor
    logic signed [W+32:0]   n_plo  [3];
    logic signed [CW-1:0]   n_phi  [3];
    logic signed [W+32:0]   r3_plo [3];
    logic signed [CW-1:0]   r3_phi [3];
    logic signed [CW-1:0]   r3_cof [NE];

    // stage 4: rejoined terms
    logic signed [DW-1:0]   r4_term [3];
    logic signed [CW-1:0]   r4_cof  [NE];

    // stage 5: determinant
    logic signed [DW-1:0]   r5_det;
    logic signed [CW-1:0]   r5_cof  [NE];

    // stage 6: magnitudes and result signs
    logic [DW-1:0]          r6_dmag;
    logic                   r6_zero;
    logic [CW-1:0]          r6_cm   [NE];
    logic [NE-1:0]          r6_neg;

    // divider lanes, index 0 is the stage 7 register
    logic [DW-1:0]          n_dv_rem  [QB][NE];
    logic [QB-1:0]          n_dv_q    [QB+1][NE];
    logic [NE-1:0]          n_dv_big;
    logic [DW-1:0]          r_dv_rem  [QB][NE];
    logic [QB-1:0]          r_dv_q    [QB+1][NE];
    logic [DW-1:0]          r_dv_dmag [QB+1];
    logic                   r_dv_zero [QB+1];
    logic [NE-1:0]          r_dv_big  [QB+1];
    logic [NE-1:0]          r_dv_neg  [QB+1];

    // output stage
    logic [W-1:0]           n_res [NE];
    logic                   n_sat;
    t_out_item              n_out;
    t_out_item              r_out;

    // whole pipe advances unless a finished result is held by the receiver
    assign w_en    = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[NSTG-1];
    assign o_data  = r_out;

    always_comb begin
        w_m[0] = i_data.in_r0c0;
        w_m[1] = i_data.in_r0c1;
        w_m[2] = i_data.in_r0c2;
        w_m[3] = i_data.in_r1c0;
        w_m[4] = i_data.in_r1c1;
        w_m[5] = i_data.in_r1c2;
        w_m[6] = i_data.in_r2c0;
        w_m[7] = i_data.in_r2c1;
        w_m[8] = i_data.in_r2c2;
        for (int k = 0; k < NE; k++) begin
            n_pa[k] = w_m[COF_A[k]] * w_m[COF_B[k]];
            n_pb[k] = w_m[COF_C[k]] * w_m[COF_D[k]];
        end
    end

    // determinant terms use cofactors 0, 3 and 6 against the first row
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_plo[j] = $signed({1'b0, r2_cof[3*j][31:0]}) * r2_m[j];
            n_phi[j] = $signed(r2_cof[3*j][63:32]) * r2_m[j];
        end
    end

    // one quotient bit per stage: shift in a zero, subtract the divisor if it fits
    always_comb begin
        logic [DW-1:0] v_sh;
        logic          v_ge;
        for (int k = 0; k < NE; k++) begin
            n_dv_big[k]  = {{(DW-CW){1'b0}}, r6_cm[k]} >= r6_dmag;
            n_dv_rem[0][k] = {{(DW-CW){1'b0}}, r6_cm[k]};
            n_dv_q[0][k]   = '0;
        end
        for (int t = 0; t < QB; t++) begin
            for (int k = 0; k < NE; k++) begin
                v_sh = {r_dv_rem[t][k][DW-2:0], 1'b0};
                v_ge = v_sh >= r_dv_dmag[t];
                n_dv_q[t+1][k] = {r_dv_q[t][k][QB-2:0], v_ge};
                if (t < QB - 1) begin
                    n_dv_rem[t+1][k] = v_ge ? v_sh - r_dv_dmag[t] : v_sh;
                end
            end
        end
    end

    // clamp, apply sign, and the singular case
    always_comb begin
        logic [QB-1:0] v_q;
        logic          v_big;
        n_sat = 1'b0;
        for (int k = 0; k < NE; k++) begin
            v_q   = r_dv_q[QB][k];
            v_big = r_dv_big[QB][k];
            if (!r_dv_neg[QB][k]) begin
                if (v_big || v_q[QB-1]) begin
                    n_res[k] = SAT_POS;
                    n_sat    = 1'b1;
                end else begin
                    n_res[k] = v_q;
                end
            end else begin
                if (v_big || v_q > SAT_NEG) begin
                    n_res[k] = SAT_NEG;
                    n_sat    = 1'b1;
                end else begin
                    n_res[k] = -v_q;
                end
            end
            if (r_dv_zero[QB]) begin
                n_res[k] = '0;
            end
        end
        n_out.out_r0c0  = n_res[0];
        n_out.out_r0c1  = n_res[1];
        n_out.out_r0c2  = n_res[2];
        n_out.out_r1c0  = n_res[3];
        n_out.out_r1c1  = n_res[4];
        n_out.out_r1c2  = n_res[5];
        n_out.out_r2c0  = n_res[6];
        n_out.out_r2c1  = n_res[7];
        n_out.out_r2c2  = n_res[8];
        n_out.singular  = r_dv_zero[QB];
        n_out.saturated = n_sat && !r_dv_zero[QB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1
            for (int k = 0; k < NE; k++) begin
                r1_pa[k] <= n_pa[k];
                r1_pb[k] <= n_pb[k];
            end
            for (int j = 0; j < 3; j++) begin
                r1_m[j] <= w_m[j];
                r2_m[j] <= r1_m[j];
            end
            // stages 2 to 5
            for (int k = 0; k < NE; k++) begin
                r2_cof[k] <= r1_pa[k] - r1_pb[k];
                r3_cof[k] <= r2_cof[k];
                r4_cof[k] <= r3_cof[k];
                r5_cof[k] <= r4_cof[k];
            end
            for (int j = 0; j < 3; j++) begin
                r3_plo[j]  <= n_plo[j];
                r3_phi[j]  <= n_phi[j];
                r4_term[j] <= (DW'(r3_phi[j]) <<< 32) + DW'(r3_plo[j]);
            end
            r5_det <= r4_term[0] + r4_term[1] + r4_term[2];
            // stage 6
            r6_dmag <= r5_det[DW-1] ? DW'(-r5_det) : DW'(r5_det);
            r6_zero <= (r5_det == '0);
            for (int k = 0; k < NE; k++) begin
                r6_cm[k]  <= r5_cof[k][CW-1] ? CW'(-r5_cof[k]) : CW'(r5_cof[k]);
                r6_neg[k] <= r5_cof[k][CW-1] ^ r5_det[DW-1];
            end
            // stage 7 and divider lanes
            r_dv_dmag[0] <= r6_dmag;
            r_dv_zero[0] <= r6_zero;
            r_dv_big[0]  <= n_dv_big;
            r_dv_neg[0]  <= r6_neg;
            for (int t = 0; t < QB; t++) begin
                r_dv_dmag[t+1] <= r_dv_dmag[t];
                r_dv_zero[t+1] <= r_dv_zero[t];
                r_dv_big[t+1]  <= r_dv_big[t];
                r_dv_neg[t+1]  <= r_dv_neg[t];
            end
            for (int t = 0; t < QB + 1; t++) begin
                for (int k = 0; k < NE; k++) begin
                    r_dv_q[t][k] <= n_dv_q[t][k];
                end
            end
            for (int t = 0; t < QB; t++) begin
                for (int k = 0; k < NE; k++) begin
                    r_dv_rem[t][k] <= n_dv_rem[t][k];
                end
            end
            // output register
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // a singular matrix never reports clamping
    a_sing_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.singular && o_data.saturated))
        else $error("singular and saturated both set");

    // a singular result carries zero entries, checked on the diagonal and on r0c1 and r1c0
    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.singular) |->
            (o_data.out_r0c0 == '0 && o_data.out_r1c1 == '0 && o_data.out_r2c2 == '0 &&
             o_data.out_r0c1 == '0 && o_data.out_r1c0 == '0))
        else $error("singular result with nonzero entries");

    // the pipe only backs up when a finished result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // reset empties the pipe
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid result right after reset");
`endif

endmodule
